### hw/rtl/lcr_pkg.sv
// Shared types, constants and helpers for the lane centre block.
// Used by lcr_accum, lcr_div and lane_centre_from_row_unit; depends on nothing.
`default_nettype none

package lcr_pkg;

  localparam int SUM_W    = 20;
  localparam int HITS_W   = 11;
  localparam int CFG_W    = 11;
  localparam int CENTRE_W = 12;

  localparam int MAX_COLS_DEF = 2048;
  localparam int MAX_ROWS_DEF = 2048;

  localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [HITS_W-1:0]   HITS_MAX   = {HITS_W{1'b1}};
  localparam logic [CENTRE_W-1:0] CENTRE_MAX = 12'sd2047;
  localparam logic [CENTRE_W-1:0] CENTRE_NONE = {CENTRE_W{1'b1}};
  localparam logic [CFG_W-1:0]    HALF_WIDTH_RST = 11'd320;

  typedef enum logic {
    CFG_HALF_WIDTH = 1'b0,
    CFG_TARGET_ROW = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_in_row;
    logic       last_in_frame;
  } pix_t;

  typedef struct packed {
    logic signed [CENTRE_W-1:0] centre_column;
    logic                       found;
  } res_t;

  // Accumulated statistics of the target row.
  typedef struct packed {
    logic              row_seen;
    logic [SUM_W-1:0]  left_sum;
    logic [HITS_W-1:0] left_hits;
    logic [SUM_W-1:0]  right_sum;
    logic [HITS_W-1:0] right_hits;
  } acc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEFT,
    ST_LEFT_WAIT,
    ST_RIGHT,
    ST_RIGHT_WAIT,
    ST_CENTRE,
    ST_OUT
  } state_t;

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] s,
                                               input logic [SUM_W:0] v);
    logic [SUM_W+1:0] t;
    t = (SUM_W+2)'(s) + (SUM_W+2)'(v);
    return (t > (SUM_W+2)'(SUM_MAX)) ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  function automatic logic [HITS_W-1:0] sat_hits(input logic [HITS_W-1:0] h);
    return (h == HITS_MAX) ? HITS_MAX : h + 1'b1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lcr_accum.sv
// Raster position counters and per-half sums and hit counts of the target row.
// Depends on lcr_pkg.
`default_nettype none

module lcr_accum
  import lcr_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire pix_t             pix,
  input  wire logic [CFG_W-1:0] half_width,
  input  wire logic [CFG_W-1:0] target_row,
  input  wire logic             clear,
  output acc_t                  acc
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int XW = (CW > CFG_W + 1) ? CW : CFG_W + 1;
  localparam int MW = (RW > CFG_W) ? RW : CFG_W;

  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  acc_t          acc_next;
  logic [XW-1:0] cx;
  logic [XW-1:0] hx;
  logic [XW-1:0] hx2;
  logic          on_row;

  assign cx     = XW'(col);
  assign hx     = XW'(half_width);
  assign hx2    = XW'({half_width, 1'b0});
  assign on_row = (MW'(row) == MW'(target_row));

  always_comb begin
    acc_next = acc;
    col_next = col;
    row_next = row;
    if (clear) begin
      acc_next = '0;
      col_next = '0;
      row_next = '0;
    end else if (take) begin
      if (on_row) begin
        acc_next.row_seen = 1'b1;
        if (pix.pixel != 8'd0) begin
          if (cx < hx) begin
            acc_next.left_sum  = sat_sum(acc.left_sum, (SUM_W+1)'(cx));
            acc_next.left_hits = sat_hits(acc.left_hits);
          end else if (cx < hx2) begin
            acc_next.right_sum  = sat_sum(acc.right_sum, (SUM_W+1)'(cx - hx));
            acc_next.right_hits = sat_hits(acc.right_hits);
          end
        end
      end
      // Oversized rows and frames wrap at the configured maxima.
      if (pix.last_in_row) begin
        col_next = '0;
        row_next = (row == RW'(MAX_ROWS - 1)) ? '0 : row + 1'b1;
      end else begin
        col_next = (col == CW'(MAX_COLS - 1)) ? '0 : col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      col <= '0;
      row <= '0;
    end else begin
      acc <= acc_next;
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lcr_div.sv
// Restoring divider, one quotient bit per cycle, shared by both half means.
// Depends on lcr_pkg.
`default_nettype none

module lcr_div
  import lcr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [HITS_W-1:0] divisor,
  output logic                   done,
  output logic [SUM_W-1:0]       quotient
);

  localparam int NW = $clog2(SUM_W + 1);

  logic [HITS_W-1:0] rem;
  logic [HITS_W-1:0] dsr;
  logic [NW-1:0]     cnt;
  logic              busy;
  logic [HITS_W:0]   trial;
  logic              ge;

  assign trial = {rem, quotient[SUM_W-1]};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient shifts in from the low end while the dividend shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], ge};
      rem      <= ge ? HITS_W'(trial - {1'b0, dsr}) : trial[HITS_W-1:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lane_centre_from_row_unit.sv
// Lane centre finder: top level with configuration, sequencer and result register.
// Depends on lcr_pkg, lcr_accum and lcr_div.
//
// Usage: a binary mask frame enters on the pix channel (pix_valid, pix_stall,
// pix) in raster order, one pixel per cycle unless stalled, with last_in_row and
// last_in_frame marking row and frame ends. On the row chosen by target_row
// the nonzero pixels are summed per half. The transaction that carries
// last_in_frame starts a per-frame sequence: one shared restoring divider
// forms the left mean and then the right mean (each divide is skipped for a
// half with no hits), and the ST_CENTRE state forms the centre. The result
// appears on the res channel (res_valid, res_stall, res) after the centre is
// formed and stays there until the receiver takes it; pix_stall is high from
// the last pixel until that result transaction completes. Within a frame the
// block takes one pixel per cycle. Configuration writes on cfg_we, cfg_index
// and cfg_data take effect at once and belong in the idle time between frames.
// Synchronous reset sets half_width to 320 and target_row to 0 and clears all
// position and accumulation state.
`default_nettype none

module lane_centre_from_row_unit
  import lcr_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pix_valid,
  output logic                  pix_stall,
  input  wire pix_t             pix,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output res_t                  res,
  input  wire logic             cfg_we,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int DW = SUM_W + 3;

  logic [CFG_W-1:0]  half_width;
  logic [CFG_W-1:0]  target_row;
  state_t            state;
  state_t            state_next;
  acc_t              acc;
  logic              take;
  logic              acc_clear;
  logic              div_start;
  logic [SUM_W-1:0]  div_dividend;
  logic [HITS_W-1:0] div_divisor;
  logic              div_done;
  logic [SUM_W-1:0]  div_q;
  logic [SUM_W-1:0]  lm;
  logic [SUM_W:0]    rm;
  logic              lm_load;
  logic              rm_load;
  logic              lm_zero;
  logic              rm_zero;
  logic              res_load;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] half_diff;
  logic signed [DW-1:0] centre_w;
  res_t              res_next;

  assign take      = pix_valid && !pix_stall;
  assign pix_stall = (state != ST_IDLE);
  assign res_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HALF_WIDTH_RST;
      target_row <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_WIDTH: half_width <= cfg_data;
        CFG_TARGET_ROW: target_row <= cfg_data;
        default: ;
      endcase
    end
  end

  lcr_accum #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .pix       (pix),
    .half_width(half_width),
    .target_row(target_row),
    .clear     (acc_clear),
    .acc       (acc)
  );

  lcr_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = acc.left_sum;
    div_divisor  = acc.left_hits;
    lm_load      = 1'b0;
    lm_zero      = 1'b0;
    rm_load      = 1'b0;
    rm_zero      = 1'b0;
    acc_clear    = 1'b0;
    res_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take && pix.last_in_frame) begin
          state_next = ST_LEFT;
        end
      end
      ST_LEFT: begin
        if (acc.left_hits == '0) begin
          lm_zero    = 1'b1;
          state_next = ST_RIGHT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_LEFT_WAIT;
        end
      end
      ST_LEFT_WAIT: begin
        if (div_done) begin
          lm_load    = 1'b1;
          state_next = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        div_dividend = acc.right_sum;
        div_divisor  = acc.right_hits;
        if (acc.right_hits == '0) begin
          rm_zero    = 1'b1;
          state_next = ST_CENTRE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_RIGHT_WAIT;
        end
      end
      ST_RIGHT_WAIT: begin
        if (div_done) begin
          rm_load    = 1'b1;
          state_next = ST_CENTRE;
        end
      end
      ST_CENTRE: begin
        res_load   = 1'b1;
        acc_clear  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (lm_zero) begin
      lm <= '0;
    end else if (lm_load) begin
      lm <= div_q;
    end
    if (rm_zero) begin
      rm <= '0;
    end else if (rm_load) begin
      rm <= (SUM_W+1)'(div_q) + (SUM_W+1)'(half_width);
    end
  end

  // Midpoint with the halving truncated toward zero, as for a signed divide.
  always_comb begin
    diff      = signed'(DW'(rm)) - signed'(DW'(lm));
    half_diff = (diff + signed'(DW'(diff[DW-1]))) >>> 1;
    centre_w  = signed'(DW'(lm)) + half_diff;
    res_next.found = acc.row_seen && ((lm != '0) || (rm != '0));
    if (!res_next.found) begin
      res_next.centre_column = CENTRE_NONE;
    end else if (centre_w > signed'(DW'(CENTRE_MAX))) begin
      res_next.centre_column = CENTRE_MAX;
    end else begin
      res_next.centre_column = centre_w[CENTRE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

### bench/lane_centre_from_row_unit_tb.sv
// Self-checking testbench for lane_centre_from_row_unit: streams mask frames
// with random gaps and stalls and checks each centre result against a predictor.
// Depends on lcr_pkg and the lane_centre_from_row_unit RTL.
module lane_centre_from_row_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int TOTAL_PIXELS   = 750;

  // Tracks the raster position and the target-row statistics of the frame in
  // flight, and holds the centre results that completed frames still owe.
  class centre_tracker;
    logic [CFG_W-1:0]  half_width = HALF_WIDTH_RST;
    logic [CFG_W-1:0]  target_row = '0;
    logic [CFG_W-1:0]  column = '0;
    logic [CFG_W-1:0]  row = '0;
    logic [SUM_W-1:0]  left_sum = '0;
    logic [HITS_W-1:0] left_hits = '0;
    logic [SUM_W-1:0]  right_sum = '0;
    logic [HITS_W-1:0] right_hits = '0;
    logic              row_seen = 1'b0;
    res_t              centres_due[$];
    int                mismatches = 0;

    function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
      if (idx == CFG_HALF_WIDTH) begin
        half_width = value;
      end else begin
        target_row = value;
      end
    endfunction

    function logic [SUM_W-1:0] clip_sum(int s);
      return (s > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
    endfunction

    function void note_pixel(pix_t p);
      int   c;
      int   hw;
      int   left_mean;
      int   right_mean;
      int   centre;
      res_t due;
      c = int'(column);
      hw = int'(half_width);
      if (row == target_row) begin
        row_seen = 1'b1;
        if (p.pixel != 8'd0) begin
          if (c < hw) begin
            left_sum = clip_sum(int'(left_sum) + c);
            if (left_hits != HITS_MAX) left_hits = left_hits + 1'b1;
          end else if (c < 2 * hw) begin
            right_sum = clip_sum(int'(right_sum) + c - hw);
            if (right_hits != HITS_MAX) right_hits = right_hits + 1'b1;
          end
        end
      end
      if (p.last_in_frame) begin
        centre = -1;
        if (row_seen) begin
          left_mean = 0;
          right_mean = 0;
          if (left_hits != 0) left_mean = int'(left_sum) / int'(left_hits);
          if (right_hits != 0) right_mean = int'(right_sum) / int'(right_hits) + hw;
          if (left_mean != 0 || right_mean != 0) begin
            // Signed division truncates toward zero, as the block must.
            centre = left_mean + (right_mean - left_mean) / 2;
            if (centre > 2047) centre = 2047;
          end
        end
        due.centre_column = CENTRE_W'(centre);
        due.found = (centre != -1);
        centres_due.push_back(due);
        column = '0;
        row = '0;
        left_sum = '0;
        left_hits = '0;
        right_sum = '0;
        right_hits = '0;
        row_seen = 1'b0;
      end else if (p.last_in_row) begin
        column = '0;
        row = row + 1'b1;
      end else begin
        column = column + 1'b1;
      end
    endfunction

    task report(string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_centre(res_t got);
      res_t want;
      if (centres_due.size() == 0) begin
        report($sformatf("centre %0d arrived with no frame pending", got.centre_column));
        return;
      end
      want = centres_due.pop_front();
      if (got.centre_column !== want.centre_column)
        report($sformatf("centre_column %0d, expected %0d",
                         got.centre_column, want.centre_column));
      if (got.found !== want.found)
        report($sformatf("found %0b, expected %0b", got.found, want.found));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             pix_valid;
  logic             pix_stall;
  pix_t             pix;
  logic             res_valid;
  logic             res_stall;
  res_t             res;
  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  centre_tracker tracker = new;
  bit            gaps_on = 1'b1;
  int            pixels_sent = 0;

  lane_centre_from_row_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Every task below is entered and left on a falling edge.
  task automatic drive_pixel(input logic [7:0] px, input bit eol, input bit eof);
    int   gap;
    pix_t p;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    p.pixel = px;
    p.last_in_row = eol;
    p.last_in_frame = eof;
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (pix_stall);
    tracker.note_pixel(p);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drive_frame(input int rows, input int len, input int hit_pct,
                             input bit ragged);
    int         r;
    int         c;
    int         row_len;
    logic [7:0] px;
    for (r = 0; r < rows; r++) begin
      row_len = ragged ? $urandom_range(1, len) : len;
      for (c = 0; c < row_len; c++) begin
        px = ($urandom_range(0, 99) < hit_pct) ? 8'($urandom_range(1, 255)) : 8'd0;
        if (r == rows - 1 && c == row_len - 1) begin
          drive_pixel(px, $urandom_range(0, 1), 1'b1);
        end else begin
          drive_pixel(px, c == row_len - 1, 1'b0);
        end
      end
    end
  endtask

  task automatic wait_idle();
    pix_valid <= 1'b0;
    while (tracker.centres_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] hw, input logic [CFG_W-1:0] row);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_HALF_WIDTH;
    cfg_data <= hw;
    tracker.set_reg(CFG_HALF_WIDTH, hw);
    @(negedge clk);
    cfg_index <= CFG_TARGET_ROW;
    cfg_data <= row;
    tracker.set_reg(CFG_TARGET_ROW, row);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Result receiver: once a result shows, hold it off for a random while if gaps are on.
  initial begin
    int hold;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      while (res_valid !== 1'b1) @(negedge clk);
      hold = gaps_on ? $urandom_range(0, 7) : 0;
      if (hold != 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (res_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.check_centre(res);
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("lane_centre_from_row_unit_tb: done, errors");
    $finish;
  end

  initial begin
    int               len_max;
    logic [CFG_W-1:0] hw;
    logic [CFG_W-1:0] row;
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_HALF_WIDTH;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: a lone hit at column zero leaves both means at zero.
    drive_pixel(8'd255, 1'b1, 1'b1);

    set_config(11'd2, 11'd0);
    drive_pixel(8'd0, 1'b0, 1'b0);
    drive_pixel(8'd255, 1'b0, 1'b0);
    drive_pixel(8'd7, 1'b0, 1'b0);
    drive_pixel(8'd1, 1'b1, 1'b1);

    // The frame ends in the middle of the target row.
    set_config(11'd2, 11'd1);
    drive_pixel(8'h80, 1'b0, 1'b0);
    drive_pixel(8'd0, 1'b1, 1'b0);
    drive_pixel(8'd0, 1'b0, 1'b0);
    drive_pixel(8'd9, 1'b0, 1'b1);
    // The target row is never reached.
    drive_pixel(8'd255, 1'b0, 1'b0);
    drive_pixel(8'd255, 1'b0, 1'b0);
    drive_pixel(8'd255, 1'b1, 1'b1);

    // With a zero half width no column belongs to either half.
    set_config(11'd0, 11'd0);
    drive_pixel(8'd255, 1'b0, 1'b0);
    drive_pixel(8'd255, 1'b0, 1'b0);
    drive_pixel(8'd255, 1'b1, 1'b1);

    // Left mean of three and no right hits: the halved difference truncates.
    set_config(11'd2047, 11'd0);
    drive_pixel(8'd0, 1'b0, 1'b0);
    drive_pixel(8'd0, 1'b0, 1'b0);
    drive_pixel(8'd0, 1'b0, 1'b0);
    drive_pixel(8'd255, 1'b1, 1'b1);

    while (pixels_sent < TOTAL_PIXELS) begin
      case ($urandom_range(0, 9))
        0: hw = 11'd0;
        1: hw = 11'd2047;
        2: hw = 11'd1024;
        3: hw = 11'($urandom_range(0, 2047));
        default: hw = 11'($urandom_range(1, 12));
      endcase
      row = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                        : 11'($urandom_range(0, 3));
      set_config(hw, row);
      gaps_on = ($urandom_range(0, 3) != 0);
      len_max = (hw <= 12) ? 2 * int'(hw) + 3 : 24;
      repeat ($urandom_range(1, 4)) begin
        drive_frame($urandom_range(1, 5), len_max, $urandom_range(0, 100),
                    $urandom_range(0, 1));
      end
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.centres_due.size() == 0) begin
      $display("lane_centre_from_row_unit_tb: done, clean");
    end else begin
      $display("lane_centre_from_row_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lcr_pkg.sv
hw/rtl/lcr_accum.sv
hw/rtl/lcr_div.sv
hw/rtl/lane_centre_from_row_unit.sv
bench/lane_centre_from_row_unit_tb.sv
